// File: src/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property that must hold even during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/aig_pkg.sv
// ----------------------------------------------------------------------------
// aig_pkg
// Types, constants and state codes shared by the structural hashing block.
// ----------------------------------------------------------------------------
package aig_pkg;

  localparam int TableSize    = 8191;
  localparam int NodeCapacity = 8192;
  localparam int LitW         = 14;
  localparam int VarW         = 13;
  localparam int KeyW         = 13;
  localparam int NodeW        = 13;
  localparam int CntW         = 14;
  localparam logic [VarW-1:0] MaxVar = 13'd8191;

  typedef enum logic [1:0] {
    OP_AND    = 2'd0,
    OP_XOR    = 2'd1,
    OP_MUX    = 2'd2,
    OP_LOOKUP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_HIT  = 2'd0,
    ST_NEW  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [LitW-1:0] lit_a;
    logic [LitW-1:0] lit_b;
    logic [LitW-1:0] lit_c;
  } in_item_t;

  typedef struct packed {
    logic [LitW-1:0] result_lit;
    logic [1:0]      status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_START,
    S_HASH,
    S_MOD,
    S_HEAD_RD,
    S_HEAD_WT,
    S_NODE_RD,
    S_NODE_WT,
    S_CHECK,
    S_APPEND,
    S_STEP_DONE,
    S_OUT
  } state_t;

  // Request from the sequencer to the AND unit
  typedef struct packed {
    logic            start;
    logic            lookup;
    logic [LitW-1:0] a;
    logic [LitW-1:0] b;
  } and_req_t;

  // Response from the AND unit
  typedef struct packed {
    logic            done;
    logic [LitW-1:0] lit;
    logic [1:0]      status;
  } and_rsp_t;

endpackage

// File: src/aig_ram.sv
// ----------------------------------------------------------------------------
// aig_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module aig_ram #(
  parameter int Width = 14,
  parameter int Depth = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/aig_and_unit.sv
// ----------------------------------------------------------------------------
// aig_and_unit
// One hashed AND: trivial rules, key computation, chain walk and append (a lookup reports a miss instead).
// ----------------------------------------------------------------------------
module aig_and_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [aig_pkg::VarW-1:0]    num_inputs,
  input  aig_pkg::and_req_t           req,
  output aig_pkg::and_rsp_t           rsp,
  output logic                        clearing
);
  import aig_pkg::*;
  `include "assert_macros.svh"

  state_t st_r, st_nxt;
  logic [LitW-1:0]  a_r, a_nxt, b_r, b_nxt, lit_r, lit_nxt;
  logic             lk_r, lk_nxt;
  logic [1:0]       sts_r, sts_nxt;
  logic [27:0]      key_r, key_nxt;
  logic [LitW-1:0]  link_r, link_nxt;
  logic [NodeW:0]   place_r, place_nxt;
  logic [CntW-1:0]  steps_r, steps_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [KeyW-1:0]  clr_r, clr_nxt;
  logic             done_r, done_nxt;

  logic             hd_we, nd_we, nx_we;
  logic [KeyW-1:0]  hd_waddr, hd_raddr;
  logic [LitW-1:0]  hd_wdata, hd_rdata;
  logic [NodeW-1:0] nd_waddr, nd_raddr, nx_waddr;
  logic [LitW-1:0]  nx_wdata, lo_rdata, hi_rdata, nx_rdata;

  logic [VarW-1:0]  v;
  logic [VarW+1:0]  kk;
  logic [VarW+1:0]  newvar;
  logic [27:0]      kfold;

  aig_ram #(.Width(LitW), .Depth(TableSize + 1)) u_head (
    .clk, .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
    .raddr(hd_raddr), .rdata(hd_rdata));
  aig_ram #(.Width(LitW), .Depth(NodeCapacity)) u_lo (
    .clk, .we(nd_we), .waddr(nd_waddr), .wdata(a_r),
    .raddr(nd_raddr), .rdata(lo_rdata));
  aig_ram #(.Width(LitW), .Depth(NodeCapacity)) u_hi (
    .clk, .we(nd_we), .waddr(nd_waddr), .wdata(b_r),
    .raddr(nd_raddr), .rdata(hi_rdata));
  aig_ram #(.Width(LitW), .Depth(NodeCapacity)) u_nx (
    .clk, .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(nd_raddr), .rdata(nx_rdata));

  assign v      = link_r[LitW-1:1];
  assign kk     = {2'b0, v} - {2'b0, num_inputs} - 15'd1;
  assign newvar = {2'b0, num_inputs} + 15'd1 + {1'b0, cnt_r};
  // fold modulo 2^13-1: x = hi*2^13 + lo == hi + lo
  assign kfold  = {15'b0, key_r[12:0]} + {13'b0, key_r[27:13]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_CLEAR;
      cnt_r  <= '0;
      clr_r  <= '0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      clr_r  <= clr_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt; b_r <= b_nxt; lit_r <= lit_nxt; lk_r <= lk_nxt;
    sts_r <= sts_nxt; key_r <= key_nxt; link_r <= link_nxt;
    place_r <= place_nxt; steps_r <= steps_nxt;
  end

  always_comb begin
    st_nxt = st_r; a_nxt = a_r; b_nxt = b_r; lit_nxt = lit_r; lk_nxt = lk_r;
    sts_nxt = sts_r; key_nxt = key_r; link_nxt = link_r; place_nxt = place_r;
    steps_nxt = steps_r; cnt_nxt = cnt_r; clr_nxt = clr_r; done_nxt = 1'b0;
    hd_we = 1'b0; hd_waddr = clr_r; hd_wdata = '0; hd_raddr = key_r[KeyW-1:0];
    nd_we = 1'b0; nd_waddr = cnt_r[NodeW-1:0]; nd_raddr = kk[NodeW-1:0];
    nx_we = 1'b0; nx_waddr = cnt_r[NodeW-1:0]; nx_wdata = '0;
    case (st_r)
      S_CLEAR: begin
        hd_we = 1'b1;
        clr_nxt = clr_r + 13'd1;
        if (clr_r == KeyW'(TableSize)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (req.start) begin
          lk_nxt = req.lookup;
          sts_nxt = ST_HIT;
          st_nxt = S_STEP_DONE;
          if (req.a < 14'd2) begin
            lit_nxt = req.a[0] ? req.b : '0;
          end else if (req.b < 14'd2) begin
            lit_nxt = req.b[0] ? req.a : '0;
          end else if (req.a == req.b) begin
            lit_nxt = req.b;
          end else if (req.a == (req.b ^ 14'd1)) begin
            lit_nxt = '0;
          end else begin
            a_nxt = (req.a > req.b) ? req.b : req.a;
            b_nxt = (req.a > req.b) ? req.a : req.b;
            st_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        key_nxt = ({2'b0, a_r[LitW-1:1], 13'b0} - ({15'b0, a_r[LitW-1:1]} << 8)
                   + {15'b0, a_r[LitW-1:1]})
                  ^ ({15'b0, b_r[LitW-1:1]} * 28'd2971)
                  ^ (a_r[0] ? 28'd911 : 28'd0) ^ (b_r[0] ? 28'd353 : 28'd0);
        st_nxt = S_MOD;
      end
      S_MOD: begin
        if (kfold[27:13] != '0) begin
          key_nxt = kfold;
        end else begin
          key_nxt = (kfold[12:0] == 13'h1FFF) ? 28'd0 : kfold;
          st_nxt = S_HEAD_RD;
        end
      end
      S_HEAD_RD: begin
        place_nxt = '0; steps_nxt = '0;
        st_nxt = S_HEAD_WT;
      end
      S_HEAD_WT: begin
        link_nxt = hd_rdata;
        st_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (link_r == '0 || steps_r >= cnt_r || v <= num_inputs ||
            kk >= {1'b0, cnt_r}) begin
          st_nxt = S_APPEND;
        end else begin
          st_nxt = S_NODE_WT;
        end
      end
      S_NODE_WT: begin
        st_nxt = S_NODE_RD;
      end
      S_NODE_RD: begin
        if (lo_rdata == a_r && hi_rdata == b_r) begin
          lit_nxt = link_r; sts_nxt = ST_HIT;
          st_nxt = S_STEP_DONE;
        end else begin
          place_nxt = {1'b0, kk[NodeW-1:0]} + 14'd1;
          link_nxt = nx_rdata;
          steps_nxt = steps_r + 14'd1;
          st_nxt = S_CHECK;
        end
      end
      S_APPEND: begin
        st_nxt = S_STEP_DONE;
        lit_nxt = '0;
        if (lk_r) begin
          sts_nxt = ST_MISS;
        end else if (cnt_r >= CntW'(NodeCapacity) || newvar > {2'b0, MaxVar}) begin
          sts_nxt = ST_FULL;
        end else begin
          nd_we = 1'b1;
          nx_we = 1'b1;
          lit_nxt = {newvar[VarW-1:0], 1'b0};
          sts_nxt = ST_NEW;
          cnt_nxt = cnt_r + 14'd1;
          if (place_r == '0) begin
            hd_we = 1'b1;
            hd_waddr = key_r[KeyW-1:0];
            hd_wdata = {newvar[VarW-1:0], 1'b0};
          end
        end
      end
      S_STEP_DONE: begin
        // link the new node behind the old tail
        if (sts_r == ST_NEW && place_r != '0) begin
          nx_we = 1'b1;
          nx_waddr = place_r[NodeW-1:0] - 13'd1;
          nx_wdata = lit_r;
        end
        done_nxt = 1'b1;
        st_nxt = S_OUT;
      end
      S_OUT: begin
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign rsp.done   = done_r;
  assign rsp.lit    = lit_r;
  assign rsp.status = sts_r;
  assign clearing   = (st_r == S_CLEAR);

  `ASSERT_CLK(a_cnt_step, clk, rst_n,
    cnt_r != $past(cnt_r) |-> cnt_r == $past(cnt_r) + 14'd1, "node count jumped")
  `ASSERT_CLK(a_new_cnt, clk, rst_n,
    done_r && sts_r == ST_NEW |-> cnt_r != '0, "new node with empty store")
  `ASSERT_CLK(a_cnt_cap, clk, rst_n,
    cnt_r <= CntW'(NodeCapacity), "node count over capacity")

endmodule

// File: src/aig_structural_hash_and.sv
// An AND miss walks the whole bucket chain and then appends; a hit stops at the
// matching node, and trivial operands skip the hash. XOR and MUX run up to three AND steps, stopping early when full.
// One request at a time; in_ready stays low until the result
// transfers, and the chain walk through node memory sets the rate.
// Reset clears the 8192 bucket head entries one per cycle, and in_ready stays
// low until that clear is done.
// ----------------------------------------------------------------------------
// aig_structural_hash_and
// Structural hashing of AND, XOR and MUX requests, and AND lookups, over an AND graph.
// ----------------------------------------------------------------------------
module aig_structural_hash_and (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  aig_pkg::in_item_t     in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output aig_pkg::out_item_t    out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import aig_pkg::*;
  `include "assert_macros.svh"

  logic [VarW-1:0] num_inputs_r;
  logic            busy_r, busy_nxt;
  logic [1:0]      step_r, step_nxt;
  logic            created_r, created_nxt;
  logic [LitW-1:0] t0_r, t0_nxt, t1_r, t1_nxt;
  in_item_t        item_r, item_nxt;
  logic            issue_r, issue_nxt;
  and_req_t        req;
  and_rsp_t        rsp;
  logic            clearing;
  logic            ov_r, ov_nxt;
  out_item_t       od_r, od_nxt;
  logic [LitW-1:0] r;

  assign pready = 1'b1;
  assign prdata = {19'b0, num_inputs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_inputs_r <= '0;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      num_inputs_r <= pwdata[VarW-1:0];
    end
  end

  aig_and_unit u_and (
    .clk, .rst_n, .num_inputs(num_inputs_r), .req, .rsp, .clearing);

  assign in_ready = !busy_r && !ov_r && !clearing;
  assign out_valid = ov_r;
  assign out_data = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; ov_r <= 1'b0; issue_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; ov_r <= ov_nxt; issue_r <= issue_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt; created_r <= created_nxt; t0_r <= t0_nxt;
    t1_r <= t1_nxt; item_r <= item_nxt; od_r <= od_nxt;
  end

  always_comb begin
    req.start = issue_r;
    req.lookup = (item_r.opcode == OP_LOOKUP);
    req.a = item_r.lit_a;
    req.b = item_r.lit_b;
    if (item_r.opcode == OP_XOR) begin
      case (step_r)
        2'd0: begin req.a = {item_r.lit_a[LitW-1:1], 1'b0};
                    req.b = {item_r.lit_b[LitW-1:1], 1'b1}; end
        2'd1: begin req.a = {item_r.lit_b[LitW-1:1], 1'b0};
                    req.b = {item_r.lit_a[LitW-1:1], 1'b1}; end
        default: begin req.a = t0_r ^ 14'd1; req.b = t1_r ^ 14'd1; end
      endcase
    end else if (item_r.opcode == OP_MUX) begin
      case (step_r)
        2'd0: begin req.a = item_r.lit_a ^ 14'd1; req.b = item_r.lit_c; end
        2'd1: begin req.a = item_r.lit_a; req.b = item_r.lit_b; end
        default: begin req.a = t0_r ^ 14'd1; req.b = t1_r ^ 14'd1; end
      endcase
    end
  end

  always_comb begin
    busy_nxt = busy_r; ov_nxt = ov_r; issue_nxt = 1'b0; step_nxt = step_r;
    created_nxt = created_r; t0_nxt = t0_r; t1_nxt = t1_r;
    item_nxt = item_r; od_nxt = od_r;
    r = rsp.lit;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    if (in_valid && in_ready) begin
      item_nxt = in_data; busy_nxt = 1'b1; issue_nxt = 1'b1;
      step_nxt = 2'd0; created_nxt = 1'b0;
    end
    if (rsp.done && busy_r) begin
      if (item_r.opcode == OP_AND || item_r.opcode == OP_LOOKUP ||
          rsp.status == ST_FULL) begin
        od_nxt.result_lit = rsp.lit; od_nxt.status = rsp.status;
        ov_nxt = 1'b1; busy_nxt = 1'b0;
      end else if (step_r != 2'd2) begin
        if (step_r == 2'd0) t0_nxt = rsp.lit; else t1_nxt = rsp.lit;
        created_nxt = created_r | (rsp.status == ST_NEW);
        step_nxt = step_r + 2'd1;
        issue_nxt = 1'b1;
      end else begin
        if (item_r.opcode == OP_XOR) begin
          r = rsp.lit ^ {13'b0, ~(item_r.lit_a[0] ^ item_r.lit_b[0])};
        end else begin
          r = rsp.lit ^ 14'd1;
        end
        od_nxt.result_lit = r;
        od_nxt.status = (created_r || rsp.status == ST_NEW) ? ST_NEW : ST_HIT;
        ov_nxt = 1'b1; busy_nxt = 1'b0;
      end
    end
  end

  `ASSERT_CLK(a_no_accept_busy, clk, rst_n,
    busy_r |-> !in_ready, "accepted while busy")
  `ASSERT_CLK(a_done_busy, clk, rst_n,
    $rose(ov_r) |-> $past(busy_r), "result without request")
  `ASSERT_ALWAYS(a_no_issue_reset, clk,
    !rst_n |=> !issue_r, "issue during reset")

endmodule
